/* hw/rtl/pft_pkg.sv */
// ----------------------------------------------------------------------------
// pft_pkg
// types and codes shared by the periodic flush timer table modules
// ----------------------------------------------------------------------------
package pft_pkg;

  // request codes
  localparam logic [1:0] REQ_REGISTER   = 2'd0;
  localparam logic [1:0] REQ_UNREGISTER = 2'd1;
  localparam logic [1:0] REQ_FLUSH      = 2'd2;
  localparam logic [1:0] REQ_TICK       = 2'd3;

  // result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EXISTS   = 2'd1;
  localparam logic [1:0] ST_MISSING  = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] timer_id;
    logic [31:0] period;
    logic [31:0] now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        flushed;
    logic [31:0] flushed_id;
    logic [31:0] old_deadline;
    logic        last;
  } res_t;

  typedef struct packed {
    logic [31:0] id;
    logic [31:0] deadline;
    logic [31:0] period;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic shift_init;
    logic shift;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       match;
    logic       full;
    logic       scan_done;
    logic       shift_done;
  } dp_stat_t;

endpackage

/* hw/rtl/pft_ctrl.sv */
// ----------------------------------------------------------------------------
// pft_ctrl
// sequencer: scan, optional shift of the sorted table, finishing write
// ----------------------------------------------------------------------------
module pft_ctrl import pft_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  output logic      busy,
  input  dp_stat_t  stat,
  output ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_SHIFT  = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;
  logic   need_shift;

  assign need_shift = (stat.op == REQ_REGISTER && !stat.match && !stat.full) ||
                      (stat.op == REQ_UNREGISTER && stat.match);

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          if (stat.op != REQ_TICK && need_shift) begin
            cmd.shift_init = 1'b1;
            state_next     = S_SHIFT;
          end else begin
            state_next = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift = 1'b1;
        if (stat.shift_done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* hw/rtl/pft_dp.sv */
// ----------------------------------------------------------------------------
// pft_dp
// sorted entry memory, scan and shift pointers, compare and result register
// ----------------------------------------------------------------------------
module pft_dp import pft_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  req_t      req,
  input  ctrl_cmd_t cmd,
  output dp_stat_t  stat,
  output res_t      res,
  output logic      res_valid
);

  localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(TABLE_ENTRIES);

  // entries 0 .. count-1 are live and kept in ascending id order
  entry_t mem [TABLE_ENTRIES];

  req_t          cur;
  logic [CW-1:0] count;
  logic [CW-1:0] ptr;
  logic [CW-1:0] pos;
  logic [CW-1:0] ptr_dec;
  logic          pipe;
  logic [AW-1:0] data_idx;
  entry_t        rd_data;
  entry_t        hit;
  logic          match;
  logic          shift_up;
  logic          due;
  logic          search;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_data;
  res_t          res_next;
  logic          res_valid_next;
  logic          reg_ok;

  assign shift_up = (cur.req_type == REQ_REGISTER);
  assign ptr_dec  = ptr - CW'(1);
  assign search   = cmd.scan && pipe && (cur.req_type != REQ_TICK);
  assign due      = cmd.scan && pipe && (cur.req_type == REQ_TICK) &&
                    (cur.now > rd_data.deadline);
  assign reg_ok   = !match && (count != FULL_COUNT);

  assign stat.op         = cur.req_type;
  assign stat.match      = match;
  assign stat.full       = (count == FULL_COUNT);
  assign stat.scan_done  = (ptr == count) && !pipe;
  assign stat.shift_done = (shift_up ? (ptr == pos) : (ptr == count)) && !pipe;

  // read port
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr[AW-1:0];
    if (cmd.scan && !cmd.shift_init && ptr < count) begin
      rd_en = 1'b1;
    end
    if (cmd.shift) begin
      if (shift_up) begin
        rd_addr = ptr_dec[AW-1:0];
        rd_en   = (ptr > pos);
      end else begin
        rd_en = (ptr < count);
      end
    end
  end

  // write port and result
  always_comb begin
    wr_en          = 1'b0;
    wr_addr        = data_idx;
    wr_data        = rd_data;
    res_next       = '0;
    res_valid_next = 1'b0;
    if (due) begin
      wr_en                 = 1'b1;
      wr_data.deadline      = rd_data.deadline + rd_data.period;
      res_valid_next        = 1'b1;
      res_next.status       = ST_OK;
      res_next.flushed      = 1'b1;
      res_next.flushed_id   = rd_data.id;
      res_next.old_deadline = rd_data.deadline;
    end
    if (cmd.shift && pipe) begin
      wr_en   = 1'b1;
      wr_addr = shift_up ? (data_idx + AW'(1)) : (data_idx - AW'(1));
    end
    if (cmd.finish) begin
      res_valid_next = 1'b1;
      res_next.last  = 1'b1;
      wr_addr        = pos[AW-1:0];
      case (cur.req_type)
        REQ_REGISTER: begin
          if (match) begin
            res_next.status = ST_EXISTS;
          end else if (!reg_ok) begin
            res_next.status = ST_FULL;
          end else begin
            wr_en            = 1'b1;
            wr_data.id       = cur.timer_id;
            wr_data.deadline = cur.now + cur.period;
            wr_data.period   = cur.period;
          end
        end
        REQ_UNREGISTER: begin
          res_next.status = match ? ST_OK : ST_MISSING;
        end
        REQ_FLUSH: begin
          if (match) begin
            wr_en                 = 1'b1;
            wr_data               = hit;
            wr_data.deadline      = hit.period + cur.now;
            res_next.flushed      = 1'b1;
            res_next.flushed_id   = hit.id;
            res_next.old_deadline = hit.deadline;
          end else begin
            res_next.status = ST_MISSING;
          end
        end
        default: begin
          res_next.status = ST_OK;
        end
      endcase
    end
  end

  // entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      pipe      <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      pipe      <= rd_en;
      res_valid <= res_valid_next;
      if (cmd.finish) begin
        if (cur.req_type == REQ_REGISTER && reg_ok) begin
          count <= count + CW'(1);
        end else if (cur.req_type == REQ_UNREGISTER && match) begin
          count <= count - CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    res <= res_next;
    if (rd_en) begin
      data_idx <= rd_addr;
    end
    if (cmd.load) begin
      cur   <= req;
      ptr   <= '0;
      pos   <= '0;
      match <= 1'b0;
    end else begin
      if (cmd.shift_init) begin
        ptr <= shift_up ? count : (pos + CW'(1));
      end else if (rd_en) begin
        ptr <= (cmd.shift && shift_up) ? ptr_dec : (ptr + CW'(1));
      end
      if (search) begin
        if (rd_data.id < cur.timer_id) begin
          pos <= pos + CW'(1);
        end else if (rd_data.id == cur.timer_id) begin
          match <= 1'b1;
          hit   <= rd_data;
        end
      end
    end
  end

`ifndef SYNTH
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond table size");

  a_port_clash: assert property (@(posedge clk) disable iff (rst)
    !(wr_en && rd_en && wr_addr == rd_addr))
    else $error("read and write of the same entry in one cycle");

  a_mid_result: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.last |->
      res.flushed && res.status == ST_OK && cur.req_type == REQ_TICK)
    else $error("non-final item outside a tick");
`endif

endmodule

/* hw/rtl/periodic_flush_timer_table.sv */
// ----------------------------------------------------------------------------
// periodic_flush_timer_table
// table of periodic timers keyed by id, with register, unregister,
// force flush and tick requests
// ----------------------------------------------------------------------------
// an item is taken when start is high and busy is low; busy then stays high
// until the request is done. results come out on res for one cycle each,
// marked by res_valid, and cannot be held off; the item with res.last set
// closes the request and appears in the cycle in which busy has dropped, so
// a new item may be started alongside it. entries are kept in one memory
// sorted by id, so every request is a walk over the n live entries through
// the single registered read port: a scan, then a shift that opens a gap
// for a register or closes it for an unregister, then a finishing step;
// force flush and tick need no shift, and a tick gives one flushed item
// per overdue entry during the scan and the closing item after it. no
// clearing pass is needed after reset: the live count starts at zero.
// ----------------------------------------------------------------------------
module periodic_flush_timer_table import pft_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output res_t res,
  output logic res_valid
);

  // command and status between sequencer and datapath
  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  // sequencer: idle, scan, shift, finish
  pft_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  // datapath: sorted entry memory, pointers, compares and result register
  pft_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .stat      (stat),
    .res       (res),
    .res_valid (res_valid)
  );

`ifndef SYNTH
  // an accepted item always makes the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("item accepted but block not busy");

  // the closing item is only shown once the block is free again
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |-> !busy)
    else $error("closing item while still busy");
`endif

endmodule

/* dv/periodic_flush_timer_table_chk.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_flush_timer_table_chk
// watches the request and result channels of the timer table, keeps its own
// copy of the table, predicts every result and compares field by field
// ----------------------------------------------------------------------------
module periodic_flush_timer_table_chk import pft_pkg::*; #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic busy,
  input  req_t req,
  input  res_t res,
  input  logic res_valid,
  output int   errors,
  output int   pending,
  output int   results_seen,
  output int   flushes_seen
);

  logic        tbl_valid    [TABLE_ENTRIES];
  logic [31:0] tbl_id       [TABLE_ENTRIES];
  logic [31:0] tbl_deadline [TABLE_ENTRIES];
  logic [31:0] tbl_period   [TABLE_ENTRIES];

  res_t expected_results [$];

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int slot_of(logic [31:0] id);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (tbl_valid[i] && tbl_id[i] == id) return i;
    end
    return -1;
  endfunction

  // apply one request to the table copy and queue the results it causes
  function automatic void predict_request(req_t r);
    res_t        out;
    int          s;
    int          best;
    logic        have_prev;
    logic [31:0] prev;
    out      = '0;
    out.last = 1'b1;
    case (r.req_type)
      REQ_REGISTER: begin
        if (slot_of(r.timer_id) >= 0) begin
          out.status = ST_EXISTS;
        end else begin
          s = -1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (!tbl_valid[i] && s < 0) s = i;
          end
          if (s < 0) begin
            out.status = ST_FULL;
          end else begin
            tbl_valid[s]    = 1'b1;
            tbl_id[s]       = r.timer_id;
            tbl_period[s]   = r.period;
            tbl_deadline[s] = r.now + r.period;
            out.status      = ST_OK;
          end
        end
        expected_results.push_back(out);
      end
      REQ_UNREGISTER: begin
        s = slot_of(r.timer_id);
        if (s < 0) begin
          out.status = ST_MISSING;
        end else begin
          tbl_valid[s] = 1'b0;
          out.status   = ST_OK;
        end
        expected_results.push_back(out);
      end
      REQ_FLUSH: begin
        s = slot_of(r.timer_id);
        if (s < 0) begin
          out.status = ST_MISSING;
        end else begin
          out.status       = ST_OK;
          out.flushed      = 1'b1;
          out.flushed_id   = tbl_id[s];
          out.old_deadline = tbl_deadline[s];
          tbl_deadline[s]  = tbl_period[s] + r.now;
        end
        expected_results.push_back(out);
      end
      default: begin
        // tick: walk live entries in ascending id order
        have_prev = 1'b0;
        prev      = '0;
        for (int k = 0; k < TABLE_ENTRIES; k++) begin
          best = -1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (tbl_valid[i] && (!have_prev || tbl_id[i] > prev) &&
                (best < 0 || tbl_id[i] < tbl_id[best])) best = i;
          end
          if (best < 0) break;
          have_prev = 1'b1;
          prev      = tbl_id[best];
          if (r.now > tbl_deadline[best]) begin
            out              = '0;
            out.status       = ST_OK;
            out.flushed      = 1'b1;
            out.flushed_id   = tbl_id[best];
            out.old_deadline = tbl_deadline[best];
            tbl_deadline[best] = tbl_deadline[best] + tbl_period[best];
            expected_results.push_back(out);
          end
        end
        out      = '0;
        out.last = 1'b1;
        expected_results.push_back(out);
      end
    endcase
  endfunction

  always @(posedge clk) begin : watch
    res_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) tbl_valid[i] = 1'b0;
      expected_results.delete();
      errors       = 0;
      results_seen = 0;
      flushes_seen = 0;
    end else begin
      // results first: a closing item may share its edge with a new request
      if (res_valid) begin
        results_seen++;
        if (res.flushed) flushes_seen++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d with nothing expected", results_seen));
        end else begin
          want = expected_results.pop_front();
          if (res.status !== want.status)
            report_mismatch($sformatf("result %0d status exp %0d got %0d",
                                      results_seen, want.status, res.status));
          if (res.flushed !== want.flushed)
            report_mismatch($sformatf("result %0d flushed exp %0b got %0b",
                                      results_seen, want.flushed, res.flushed));
          if (res.flushed_id !== want.flushed_id)
            report_mismatch($sformatf("result %0d flushed_id exp %h got %h",
                                      results_seen, want.flushed_id, res.flushed_id));
          if (res.old_deadline !== want.old_deadline)
            report_mismatch($sformatf("result %0d old_deadline exp %h got %h",
                                      results_seen, want.old_deadline, res.old_deadline));
          if (res.last !== want.last)
            report_mismatch($sformatf("result %0d last exp %0b got %0b",
                                      results_seen, want.last, res.last));
        end
      end
      if (start && !busy) predict_request(req);
    end
    pending = expected_results.size();
  end

endmodule

/* dv/periodic_flush_timer_table_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// periodic_flush_timer_table_tb
// drives register, unregister, flush and tick requests into the timer table
// and leaves the checking to a checker module alongside the block
// ----------------------------------------------------------------------------
module periodic_flush_timer_table_tb import pft_pkg::*; ();

  localparam int TABLE_ENTRIES = 16;
  localparam int POOL_SIZE     = 24;
  // worst busy stretch is an unregister of the lowest id in a full table,
  // plus the longest sender gap; the limit is many times that
  localparam int STALL_LIMIT   = 400;
  localparam int DRAIN_CYCLES  = 2 * TABLE_ENTRIES + 8;

  logic clk   = 1'b0;
  logic rst   = 1'b1;
  logic start = 1'b0;
  req_t req   = '0;
  logic busy;
  res_t res;
  logic res_valid;

  int errors;
  int pending;
  int results_seen;
  int flushes_seen;
  int items_sent   = 0;
  int stall_cycles = 0;

  // ids that random requests mostly draw from, so that they hit live entries
  logic [31:0] id_pool [POOL_SIZE];
  // running notion of time, so that ticks find overdue entries
  logic [31:0] sim_now;

  always #5 clk = ~clk;

  periodic_flush_timer_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .req      (req),
    .res      (res),
    .res_valid(res_valid)
  );

  periodic_flush_timer_table_chk #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) table_chk (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .req         (req),
    .res         (res),
    .res_valid   (res_valid),
    .errors      (errors),
    .pending     (pending),
    .results_seen(results_seen),
    .flushes_seen(flushes_seen)
  );

  // watchdog: any cycle with neither an accepted item nor a result counts
  always @(posedge clk) begin
    if (rst || (start && !busy) || res_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("timeout: no item or result for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  // present one item from the falling edge and hold it until it is taken;
  // start is left high so that a following item runs on without a gap
  task automatic send_request(logic [1:0] rt, logic [31:0] id, logic [31:0] per,
                              logic [31:0] nw);
    req_t r;
    r.req_type = rt;
    r.timer_id = id;
    r.period   = per;
    r.now      = nw;
    @(negedge clk);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  // sender gap: start drops, with junk on the request bus meanwhile
  task automatic sender_pause(int idle_pct);
    if ($urandom_range(0, 99) < idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
      req   <= {2'($urandom), 32'($urandom), 32'($urandom), 32'($urandom)};
      repeat ($urandom_range(0, 5)) @(negedge clk);
    end
  endtask

  function automatic logic [31:0] pick_id();
    if ($urandom_range(0, 99) < 85) return id_pool[$urandom_range(0, POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_period();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel == 0) return '0;
    if (sel <= 6) return $urandom_range(1, 40);
    if (sel <= 8) return $urandom;
    return 32'hFFFF_FFFF;
  endfunction

  // one random item; time creeps forward so that deadlines fall due, with
  // the odd wild value for now
  task automatic random_request();
    int          sel;
    logic [1:0]  rt;
    logic [31:0] nw;
    sel     = $urandom_range(0, 99);
    rt      = (sel < 30) ? REQ_REGISTER :
              (sel < 50) ? REQ_UNREGISTER :
              (sel < 68) ? REQ_FLUSH : REQ_TICK;
    sim_now = sim_now + $urandom_range(0, 12);
    nw      = ($urandom_range(0, 99) < 80) ? sim_now : 32'($urandom);
    send_request(rt, pick_id(), pick_period(), nw);
  endtask

  task automatic run_phase(int n_items, int idle_pct, logic [31:0] t0);
    sim_now = t0;
    repeat (n_items) begin
      sender_pause(idle_pct);
      random_request();
    end
  endtask

  initial begin
    id_pool[0] = 32'h0000_0000;
    id_pool[1] = 32'hFFFF_FFFF;
    id_pool[2] = 32'h0000_0001;
    id_pool[3] = 32'h8000_0000;
    id_pool[4] = 32'h7FFF_FFFF;
    for (int i = 5; i < POOL_SIZE; i++) id_pool[i] = $urandom;

    // synchronous reset, released on a falling edge
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extreme ids, zero period, wrapped deadline, duplicates
    send_request(REQ_REGISTER, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_request(REQ_REGISTER, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(REQ_REGISTER, 32'h0000_0000, 32'h0000_0005, 32'h0000_0007);
    // missing ids for unregister and flush
    send_request(REQ_UNREGISTER, 32'h0000_1234, 32'h0, 32'h0);
    send_request(REQ_FLUSH, 32'h0000_1234, 32'h0, 32'h5);
    // flush a live entry, deadline moves to now plus period with wrap
    send_request(REQ_FLUSH, 32'hFFFF_FFFF, 32'h0, 32'h0000_0005);
    // tick at the top of time reports both, tick at zero reports nothing
    send_request(REQ_TICK, 32'h0, 32'h0, 32'hFFFF_FFFF);
    send_request(REQ_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_request(REQ_UNREGISTER, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // fill the table from the pool, then one more for the full case
    for (int k = 0; k < TABLE_ENTRIES - 1; k++) begin
      send_request(REQ_REGISTER, id_pool[k + 4], $urandom_range(1, 40), 32'd100);
    end
    send_request(REQ_REGISTER, id_pool[TABLE_ENTRIES + 4], 32'd3, 32'd100);
    // a tick over a full table with everything overdue
    send_request(REQ_TICK, 32'h0, 32'h0, 32'h8000_0000);

    // random: sender idling at 28 percent, then 61, then not at all;
    // the middle phase runs time across the 2^32 wrap
    run_phase(85, 28, 32'd200);
    run_phase(85, 61, 32'hFFFF_FF80);
    run_phase(84, 0, 32'($urandom));

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0 || busy) @(negedge clk);
    // quiet time to catch any stray result
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("covered %0d items: duplicates, missing ids, a full table, zero periods",
             items_sent);
    $display("and wrapped deadlines; %0d results checked, %0d of them flushed entries",
             results_seen, flushes_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
